### rtl/ghcbf_pkg.sv
// types, constants and gear table for the gear hash chunk boundary finder
package ghcbf_pkg;

  localparam int unsigned GearDepth = 256;
  localparam logic [63:0] GearSeed = 64'hA15C_0DE5_A15C_0DE5;
  localparam logic [23:0] MaxChunkLimit = 24'd8388608;

  typedef logic [GearDepth-1:0][63:0] gear_table_t;

  typedef enum logic {
    CMD_DATA     = 1'b0,
    CMD_FINALIZE = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_CUT    = 1'b0,
    STATUS_REJECT = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    CFG_MIN_SIZE = 2'd0,
    CFG_AVG_LOG2 = 2'd1,
    CFG_MAX_SIZE = 2'd2
  } cfg_index_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] chunk_offset;
    logic [23:0] chunk_length;
    logic        from_finalize;
  } out_word_t;

  function automatic logic [63:0] mix64(input logic [63:0] v);
    logic [63:0] t;
    begin
      t = v + 64'h9E37_79B9_7F4A_7C15;
      t = (t ^ (t >> 30)) * 64'hBF58_476D_1CE4_E5B9;
      t = (t ^ (t >> 27)) * 64'h94D0_49BB_1331_11EB;
      return t ^ (t >> 31);
    end
  endfunction

  function automatic gear_table_t build_gear();
    gear_table_t tab;
    logic [63:0] s;
    begin
      s = GearSeed;
      for (int i = 0; i < GearDepth; i++) begin
        s = mix64(s);
        tab[i] = s;
      end
      return tab;
    end
  endfunction

  localparam gear_table_t GearTable = build_gear();

endpackage

### rtl/gear_hash_chunk_boundary_finder.sv
// gear hash chunk boundary finder top level
// a result word is registered and valid in the cycle after its input word is taken
// throughput: one input word per cycle while the output is not stalled, set by the loop through
//   the hash, byte count and chunk start registers
// reset: hash, count, chunk start and lock cleared, registers back to their defaults
module gear_hash_chunk_boundary_finder
  import ghcbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o
);

  logic [23:0] min_size_q;
  logic [4:0]  avg_log2_q;
  logic [23:0] max_size_q;

  logic [63:0] hash_q, hash_d;
  logic [23:0] cnt_q, cnt_d;
  logic [63:0] start_q, start_d;
  logic        locked_q, locked_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, res;

  logic        in_fire;
  logic        res_valid;
  logic        cut;
  logic [63:0] hash_upd;
  logic [23:0] cnt_inc;
  logic [23:0] eff_max;
  logic [31:0] mask_s;
  logic [31:0] mask_l;
  logic        below_avg;
  logic [23:0] cut_len;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= 24'd2048;
      avg_log2_q <= 5'd13;
      max_size_q <= 24'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MIN_SIZE: min_size_q <= cfg_data_i;
        CFG_AVG_LOG2: avg_log2_q <= cfg_data_i[4:0];
        CFG_MAX_SIZE: max_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cut decision
  assign hash_upd = {hash_q[62:0], 1'b0} + GearTable[in_data_i.data_byte];
  assign cnt_inc  = cnt_q + 24'd1;
  assign eff_max  = (max_size_q < MaxChunkLimit) ? max_size_q : MaxChunkLimit;
  assign mask_s   = ~({32{1'b1}} << ({1'b0, avg_log2_q} + 6'd1));
  assign mask_l   = (avg_log2_q == 5'd0) ? '0
                                          : ~({32{1'b1}} << (avg_log2_q - 5'd1));
  assign below_avg = (avg_log2_q >= 5'd24) || (cnt_inc < (24'd1 << avg_log2_q));

  always_comb begin
    hash_d    = hash_q;
    cnt_d     = cnt_q;
    start_d   = start_q;
    locked_d  = locked_q;
    res_valid = 1'b0;
    cut       = 1'b0;
    cut_len   = cnt_q;
    res       = '{status: STATUS_CUT, chunk_offset: start_q, chunk_length: cnt_q,
                  from_finalize: 1'b0};
    if (in_fire) begin
      if (locked_q) begin
        res_valid = 1'b1;
        res       = '{status: STATUS_REJECT, chunk_offset: '0, chunk_length: '0,
                      from_finalize: 1'b0};
      end else if (in_data_i.cmd == CMD_FINALIZE) begin
        locked_d = 1'b1;
        if (cnt_q != 24'd0) begin
          cut                 = 1'b1;
          res_valid           = 1'b1;
          res.from_finalize   = 1'b1;
        end
      end else begin
        hash_d  = hash_upd;
        cnt_d   = cnt_inc;
        cut_len = cnt_inc;
        if (cnt_inc < min_size_q) begin
          cut = 1'b0;
        end else if (cnt_inc >= eff_max) begin
          cut = 1'b1;
        end else if (below_avg) begin
          cut = (hash_upd[31:0] & mask_s) == '0;
        end else begin
          cut = (hash_upd[31:0] & mask_l) == '0;
        end
        res_valid        = cut;
        res.chunk_length = cnt_inc;
      end
      if (cut) begin
        start_d = start_q + {40'd0, cut_len};
        cnt_d   = '0;
        hash_d  = '0;
      end
    end
  end

  always_comb begin
    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= '0;
      cnt_q       <= '0;
      start_q     <= '0;
      locked_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      locked_q    <= locked_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock cleared after finalize");

  finalize_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.cmd == CMD_FINALIZE) |=> locked_q)
    else $error("finalize did not lock");

  reject_when_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && locked_q) |=> (out_valid_q && out_q.status == STATUS_REJECT
                               && $stable(cnt_q) && $stable(start_q)))
    else $error("word after finalize not rejected or state changed");

  cut_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cut) |=> (cnt_q == '0 && hash_q == '0 && out_valid_q))
    else $error("cut did not clear hash and count");

endmodule

### bench/tb_gear_hash_chunk_boundary_finder.sv
// self-checking testbench for the gear hash chunk boundary finder, with its own chunking predictor
`timescale 1ns / 100ps

module tb_gear_hash_chunk_boundary_finder;
  import ghcbf_pkg::*;

  localparam logic [1:0]  CfgSpare   = 2'd3;
  localparam logic [23:0] ChunkLimit = 24'd8388608;
  localparam logic [63:0] TableSeed  = 64'hA15C_0DE5_A15C_0DE5;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_data_o;

  logic [63:0] gear_words [256];
  logic [63:0] gear_hash   = '0;
  logic [23:0] chunk_len   = '0;
  logic [63:0] chunk_start = '0;
  bit          stream_locked = 1'b0;
  logic [23:0] min_len   = 24'd2048;
  logic [4:0]  avg_shift = 5'd13;
  logic [23:0] max_len   = 24'd65536;

  out_word_t pending_boundaries [$];
  int        mismatches    = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  gear_hash_chunk_boundary_finder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("gear_hash_chunk_boundary_finder test failed");
    $finish;
  end

  function automatic logic [63:0] splitmix_next(input logic [63:0] z);
    z = z + 64'h9E37_79B9_7F4A_7C15;
    z = (z ^ (z >> 30)) * 64'hBF58_476D_1CE4_E5B9;
    z = (z ^ (z >> 27)) * 64'h94D0_49BB_1331_11EB;
    return z ^ (z >> 31);
  endfunction

  task automatic advance_chunker(input in_word_t w);
    out_word_t   r;
    logic [63:0] avg_len;
    logic [63:0] mask_small;
    logic [63:0] mask_large;
    logic [23:0] max_eff;
    bit          cut_now;
    int          k;
    k          = avg_shift;
    avg_len    = 64'd1 << k;
    mask_small = (64'd1 << (k + 1)) - 64'd1;
    mask_large = (k == 0) ? 64'd0 : (64'd1 << (k - 1)) - 64'd1;
    max_eff    = (max_len < ChunkLimit) ? max_len : ChunkLimit;
    r          = '0;
    cut_now    = 1'b0;
    if (stream_locked) begin
      r.status = STATUS_REJECT;
      pending_boundaries = {pending_boundaries, r};
      return;
    end
    if (w.cmd == CMD_FINALIZE) begin
      stream_locked   = 1'b1;
      cut_now         = (chunk_len != '0);
      r.from_finalize = 1'b1;
    end else begin
      chunk_len = chunk_len + 24'd1;
      gear_hash = (gear_hash << 1) + gear_words[w.data_byte];
      if (chunk_len >= min_len) begin
        if (chunk_len >= max_eff) begin
          cut_now = 1'b1;
        end else if (64'(chunk_len) < avg_len) begin
          cut_now = ((gear_hash & mask_small) == '0);
        end else begin
          cut_now = ((gear_hash & mask_large) == '0);
        end
      end
    end
    if (cut_now) begin
      r.status       = STATUS_CUT;
      r.chunk_offset = chunk_start;
      r.chunk_length = chunk_len;
      chunk_start    = chunk_start + 64'(chunk_len);
      chunk_len      = '0;
      gear_hash      = '0;
      pending_boundaries = {pending_boundaries, r};
    end
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input cmd_e cmd, input logic [7:0] data_byte);
    in_word_t w;
    w.cmd       = cmd;
    w.data_byte = data_byte;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_chunker(w);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_MIN_SIZE: min_len   = value;
      CFG_AVG_LOG2: avg_shift = value[4:0];
      CFG_MAX_SIZE: max_len   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // finalize on an empty chunk and most bytes give no word, so wait until no expected word is pending, then idle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_boundaries.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_default_registers();
    send_word(CMD_DATA, 8'h00);
    send_word(CMD_DATA, 8'hFF);
    send_word(CMD_DATA, 8'h01);
    send_word(CMD_DATA, 8'h80);
    send_word(CMD_DATA, 8'h7F);
  endtask

  task automatic test_min_above_max();
    drain_results();
    write_register(CFG_MIN_SIZE, 24'd12);
    write_register(CFG_AVG_LOG2, 24'd6);
    write_register(CFG_MAX_SIZE, 24'd4);
    repeat (7) send_word(CMD_DATA, 8'($urandom()));
  endtask

  task automatic test_zero_large_mask();
    drain_results();
    write_register(CFG_AVG_LOG2, 24'd0);
    write_register(CFG_MIN_SIZE, 24'd1);
    write_register(CFG_MAX_SIZE, 24'hFF_FFFF);
    send_word(CMD_DATA, 8'h00);
    send_word(CMD_DATA, 8'hFF);
    send_word(CMD_DATA, 8'hAA);
    send_word(CMD_DATA, 8'h55);
  endtask

  task automatic test_zero_limits();
    drain_results();
    write_register(CFG_MIN_SIZE, 24'd0);
    write_register(CFG_MAX_SIZE, 24'd0);
    send_word(CMD_DATA, 8'h3C);
    send_word(CMD_DATA, 8'hC3);
  endtask

  task automatic test_wide_registers();
    drain_results();
    write_register(CFG_MIN_SIZE, 24'hFF_FFFF);
    write_register(CFG_AVG_LOG2, 24'hFF_FFFF);
    write_register(CFG_MAX_SIZE, 24'hFF_FFFF);
    write_register(CfgSpare, 24'hFF_FFFF);
    write_register(CfgSpare, 24'h00_0000);
    repeat (5) send_word(CMD_DATA, 8'($urandom()));
  endtask

  task automatic randomise_registers();
    int          k;
    logic [23:0] max_pick;
    k = ($urandom_range(5) == 0) ? $urandom_range(9, 31) : $urandom_range(0, 8);
    case ($urandom_range(3))
      0: max_pick = 24'($urandom_range(0, 400));
      1: max_pick = 24'hFF_FFFF;
      2: max_pick = ChunkLimit;
      default: max_pick = ChunkLimit - 24'd1;
    endcase
    if (k > 8) max_pick = 24'($urandom_range(0, 400));
    write_register(CFG_MIN_SIZE, 24'($urandom_range(0, 96)));
    write_register(CFG_AVG_LOG2, {19'($urandom()), 5'(k)});
    write_register(CFG_MAX_SIZE, max_pick);
    if ($urandom_range(3) == 0) write_register(CfgSpare, 24'($urandom()));
  endtask

  task automatic test_random_stream(input int sender_gap_pct, input int receiver_stall_pct);
    send_idle_pct = sender_gap_pct;
    recv_idle_pct = receiver_stall_pct;
    repeat (5) begin
      drain_results();
      randomise_registers();
      repeat (100) send_word(CMD_DATA, 8'($urandom()));
    end
  endtask

  task automatic test_finalize_and_lock();
    drain_results();
    if ($urandom_range(1) == 0) begin
      // every byte cuts, so finalize meets an empty chunk
      write_register(CFG_MIN_SIZE, 24'd0);
      write_register(CFG_MAX_SIZE, 24'd0);
      send_word(CMD_DATA, 8'($urandom()));
    end else begin
      write_register(CFG_MIN_SIZE, 24'hFF_FFFF);
      repeat (3) send_word(CMD_DATA, 8'($urandom()));
    end
    send_word(CMD_FINALIZE, 8'($urandom()));
    send_word(CMD_DATA, 8'($urandom()));
    send_word(CMD_FINALIZE, 8'($urandom()));
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_boundaries.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_boundaries.pop_front();
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.chunk_offset !== want.chunk_offset) begin
          $display("%0t: chunk_offset expected %h got %h", $time, want.chunk_offset,
                   out_data_o.chunk_offset);
          mismatches++;
        end
        if (out_data_o.chunk_length !== want.chunk_length) begin
          $display("%0t: chunk_length expected %0d got %0d", $time, want.chunk_length,
                   out_data_o.chunk_length);
          mismatches++;
        end
        if (out_data_o.from_finalize !== want.from_finalize) begin
          $display("%0t: from_finalize expected %0d got %0d", $time, want.from_finalize,
                   out_data_o.from_finalize);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [63:0] seed;
    int          waited;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    seed = TableSeed;
    for (int i = 0; i < 256; i++) begin
      seed          = splitmix_next(seed);
      gear_words[i] = seed;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 30;
    test_default_registers();
    test_min_above_max();
    test_zero_large_mask();
    test_zero_limits();
    test_wide_registers();
    test_random_stream(38, 75);
    test_random_stream(75, 38);
    test_random_stream(0, 0);
    test_finalize_and_lock();

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_boundaries.size() != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
    if (pending_boundaries.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_boundaries.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("gear_hash_chunk_boundary_finder test passed");
    end else begin
      $display("gear_hash_chunk_boundary_finder test failed");
    end
    $finish;
  end

endmodule
